[hdl/srfp_pkg.sv]
// srfp_pkg: shared types, codes and constants for the sonar range frame parser.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package srfp_pkg;

   // field widths
   localparam int ByteW   = 8;
   localparam int DistW   = 10;
   localparam int StatusW = 2;
   localparam int PhaseW  = 2;
   localparam int CountW  = 2;
   localparam int IndexW  = 1;

   typedef logic [ByteW-1:0]   byte_type;
   typedef logic [DistW-1:0]   dist_type;
   typedef logic [StatusW-1:0] status_type;
   typedef logic [PhaseW-1:0]  phase_type;
   typedef logic [CountW-1:0]  count_type;
   typedef logic [IndexW-1:0]  index_type;

   // parser phases
   localparam phase_type PH_WAIT_R = 2'd0;
   localparam phase_type PH_DIGITS = 2'd1;
   localparam phase_type PH_TERM   = 2'd2;

   // result status codes
   localparam status_type ST_BUSY  = 2'd0;
   localparam status_type ST_ERROR = 2'd1;
   localparam status_type ST_NEW   = 2'd2;

   // register indexes
   localparam index_type REG_MIN_DIST = 1'd0;
   localparam index_type REG_MAX_DIST = 1'd1;

   // frame characters
   localparam byte_type CHAR_START = 8'h52;   // 'R'
   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type CHAR_ZERO  = 8'h30;
   localparam byte_type CHAR_NINE  = 8'h39;

   localparam count_type DIGITS_PER_FRAME = 2'd3;

   // reset values
   localparam dist_type MIN_DIST_RST = 10'd20;
   localparam dist_type MAX_DIST_RST = 10'd800;
   localparam dist_type HELD_RST     = 10'd20;

endpackage

[hdl/srfp_req_if.sv]
// srfp_req_if: valid/ready channel carrying one received serial byte per word.
// Depends on srfp_pkg.
`timescale 1ns / 1ps

interface srfp_req_if
   import srfp_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/srfp_rsp_if.sv]
// srfp_rsp_if: valid/ready channel carrying one parse result per word.
// Depends on srfp_pkg.
`timescale 1ns / 1ps

interface srfp_rsp_if
   import srfp_pkg::*;
   ();
   logic       valid;
   logic       ready;
   status_type status;
   dist_type   distance_cm;

   modport source (output valid, output status, output distance_cm, input ready);
   modport sink   (input valid, input status, input distance_cm, output ready);
endinterface

[hdl/sonar_range_frame_parser.sv]
// sonar_range_frame_parser: parses 'R' ddd CR range frames, one byte per word.
// Latency: a result word appears on rsp the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single result register is refilled in the
// cycle it drains, so req stalls only while a result waits with rsp.ready low.
// Reset (synchronous, active high): waiting for 'R', held distance 20 cm,
// bounds 20..800 cm, no result pending.
`timescale 1ns / 1ps

module sonar_range_frame_parser
   import srfp_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   srfp_req_if.sink    req_chan,
   srfp_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  index_type   csr_index,
   input  dist_type    csr_wdata
   );

   // configuration registers
   dist_type min_dist_ff, max_dist_ff;

   // parser state
   phase_type phase_ff,   phase_in;
   count_type count_ff,   count_in;
   dist_type  partial_ff, partial_in;
   dist_type  held_ff,    held_in;

   // result register
   logic       rsp_valid_ff;
   status_type status_ff, status_in;
   dist_type   dist_ff;

   logic     accept;
   logic     is_digit;
   byte_type digit_off;
   logic [DistW+3:0] scaled;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MIN_DIST_RST;
         max_dist_ff <= MAX_DIST_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_DIST: min_dist_ff <= csr_wdata;
            REG_MAX_DIST: max_dist_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next-state and status for the incoming byte
   always_comb begin
      is_digit   = (req_chan.rx_byte >= CHAR_ZERO) && (req_chan.rx_byte <= CHAR_NINE);
      digit_off  = req_chan.rx_byte - CHAR_ZERO;
      scaled     = {4'd0, partial_ff} * 14'd10 + {{(DistW+4-ByteW){1'b0}}, digit_off};
      phase_in   = phase_ff;
      count_in   = count_ff;
      partial_in = partial_ff;
      held_in    = held_ff;
      status_in  = ST_BUSY;
      case (phase_ff)
         PH_DIGITS: begin
            if (is_digit) begin
               partial_in = scaled[DistW-1:0];
               count_in   = count_ff + 2'd1;
               if (count_in == DIGITS_PER_FRAME) begin
                  phase_in = PH_TERM;
               end
            end else begin
               status_in = ST_ERROR;
               phase_in  = PH_WAIT_R;
            end
         end
         PH_TERM: begin
            if (req_chan.rx_byte != CHAR_CR) begin
               status_in = ST_ERROR;
            end else if (partial_ff < min_dist_ff || partial_ff > max_dist_ff) begin
               status_in = ST_ERROR;
            end else begin
               held_in   = partial_ff;
               status_in = ST_NEW;
            end
            phase_in = PH_WAIT_R;
         end
         default: begin
            // waiting for 'R'; the unused code behaves the same
            count_in   = '0;
            partial_in = '0;
            if (req_chan.rx_byte == CHAR_START) begin
               phase_in = PH_DIGITS;
            end else begin
               status_in = ST_ERROR;
               phase_in  = PH_WAIT_R;
            end
         end
      endcase
   end

   // parser state update on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT_R;
         count_ff   <= '0;
         partial_ff <= '0;
         held_ff    <= HELD_RST;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         partial_ff <= partial_in;
         held_ff    <= held_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         dist_ff   <= held_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.distance_cm = dist_ff;

   // checks
   a_term_after_three: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TERM |-> count_ff == DIGITS_PER_FRAME)
      else $error("terminator phase entered without three digits");

   a_new_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_NEW |->
         dist_ff >= min_dist_ff && dist_ff <= max_dist_ff)
      else $error("new reading outside configured bounds");

   a_bad_start: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_WAIT_R && req_chan.rx_byte != CHAR_START |=>
         rsp_valid_ff && status_ff == ST_ERROR)
      else $error("wrong start byte not reported as error");

   a_held_on_new_only: assert property (@(posedge clock) disable iff (reset)
      held_ff != $past(held_ff) && !$past(reset) |-> rsp_valid_ff && status_ff == ST_NEW)
      else $error("held distance changed without a new reading");

endmodule
